@@ rtl/core/adbrx_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adbrx_pkg
// Shared types and constants of the ADB message receive checker.
// ----------------------------------------------------------------------------
package adbrx_pkg;

    localparam int MAX_PAYLOAD = 4096;
    localparam int PAY_AW      = $clog2(MAX_PAYLOAD);

    localparam logic [31:0] HDR_BYTES   = 32'd24;
    localparam logic [12:0] MAX_LEN_RST = 13'd4096;

    // request action codes
    localparam logic [2:0] ACT_ARM  = 3'd0;
    localparam logic [2:0] ACT_BYTE = 3'd1;
    localparam logic [2:0] ACT_END  = 3'd2;
    localparam logic [2:0] ACT_IDLE = 3'd3;
    localparam logic [2:0] ACT_READ = 3'd4;

    // status codes
    localparam logic [1:0] ST_BUSY  = 2'd0;
    localparam logic [1:0] ST_OK    = 2'd1;
    localparam logic [1:0] ST_ERROR = 2'd2;

    typedef struct packed {
        logic [2:0]  action;
        logic [7:0]  data_byte;
        logic        transfer_ok;
        logic [11:0] read_index;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] command;
        logic [31:0] first_argument;
        logic [31:0] second_argument;
        logic [31:0] payload_len;
        logic [7:0]  read_byte;
    } out_item_t;

    typedef struct packed {
        logic              wr_en;
        logic [PAY_AW-1:0] wr_addr;
        logic [7:0]        wr_data;
        logic              rd_en;
        logic [PAY_AW-1:0] rd_addr;
    } payload_req_t;

endpackage

@@ rtl/core/adbrx_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adbrx_if
// Valid/ready channels carrying requests and results of the checker.
// ----------------------------------------------------------------------------
interface adbrx_in_if;
    logic                 valid;
    logic                 ready;
    adbrx_pkg::in_item_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface adbrx_out_if;
    logic                 valid;
    logic                 ready;
    adbrx_pkg::out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/core/adb_packet_receive_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adb_packet_receive_checker
// Checks an ADB header and payload byte stream and reports status per request.
// ----------------------------------------------------------------------------
//  channel   | dir | handshake     | payload
//  req_ch    | in  | valid/ready   | action, data_byte, transfer_ok, read_index
//  rsp_ch    | out | valid/ready   | status, header words, read_byte
//  cfg_wr_*  | in  | write enable  | max_payload_len (13 bits)
//
// one request per cycle sustained while results are taken; a result is offered after its request passes
// the input register, then state update and buffer access into the result register
// the payload buffer read is registered alongside the result register
// rst_n clears state, header words, counters and max_payload_len to 4096
// a stalled result holds the pipeline; one more request may wait in the input register
// ----------------------------------------------------------------------------
module adb_packet_receive_checker
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [12:0]        cfg_wr_data,
    adbrx_in_if.sink           req_ch,
    adbrx_out_if.source        rsp_ch
);

    typedef enum logic [1:0] {PH_IDLE, PH_HEADER, PH_DATA, PH_ERROR} phase_t;

    logic [12:0]                 max_len_reg;
    logic                        s1_valid_reg;
    adbrx_pkg::in_item_t         s1_item_reg;
    phase_t                      phase_reg, phase_next;
    logic [31:0]                 hdr_reg [6];
    logic [31:0]                 hdr_next [6];
    logic [31:0]                 count_reg, count_next;
    logic [31:0]                 sum_reg, sum_next;
    logic                        out_valid_reg;
    adbrx_pkg::out_item_t        out_item_reg, out_item_next;
    logic                        out_rd_sel_reg;

    logic                        advance;
    logic                        proc;
    logic [31:0]                 count_inc;
    logic                        hdr_bad;
    logic                        data_bad;
    logic                        rd_in_range;
    logic [7:0]                  rd_data;
    adbrx_pkg::payload_req_t     buf_port;
    adbrx_pkg::out_item_t        rsp_data;

    assign advance      = !out_valid_reg || rsp_ch.ready;
    assign proc         = s1_valid_reg && advance;
    assign req_ch.ready = !s1_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= adbrx_pkg::MAX_LEN_RST;
        end
        else if (cfg_wr_en)
        begin
            max_len_reg <= cfg_wr_data;
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (req_ch.ready)
        begin
            s1_valid_reg <= req_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_ch.valid && req_ch.ready)
        begin
            s1_item_reg <= req_ch.data;
        end
    end

    assign count_inc = (count_reg == 32'hFFFF_FFFF) ? count_reg : count_reg + 32'd1;
    assign hdr_bad   = !s1_item_reg.transfer_ok || (count_reg != adbrx_pkg::HDR_BYTES) ||
                       (hdr_reg[0] != ~hdr_reg[5]) ||
                       (hdr_reg[3] > {19'd0, max_len_reg});
    assign data_bad  = !s1_item_reg.transfer_ok || (count_reg != hdr_reg[3]) ||
                       (sum_reg != hdr_reg[4]);
    assign rd_in_range = 32'(s1_item_reg.read_index) < 32'(adbrx_pkg::MAX_PAYLOAD);

    always_comb
    begin
        phase_next = phase_reg;
        hdr_next   = hdr_reg;
        count_next = count_reg;
        sum_next   = sum_reg;

        buf_port.wr_en   = 1'b0;
        buf_port.wr_addr = count_reg[adbrx_pkg::PAY_AW-1:0];
        buf_port.wr_data = s1_item_reg.data_byte;
        buf_port.rd_en   = proc;
        buf_port.rd_addr = adbrx_pkg::PAY_AW'(s1_item_reg.read_index);

        unique case (s1_item_reg.action)
            adbrx_pkg::ACT_ARM:
            begin
                phase_next = PH_HEADER;
                count_next = 32'd0;
                sum_next   = 32'd0;
            end
            adbrx_pkg::ACT_BYTE:
            begin
                if (phase_reg == PH_HEADER)
                begin
                    // bytes past the header are counted only
                    if (count_reg < adbrx_pkg::HDR_BYTES)
                    begin
                        hdr_next[count_reg[4:2]][{count_reg[1:0], 3'b000} +: 8] =
                            s1_item_reg.data_byte;
                    end
                    count_next = count_inc;
                end
                else if (phase_reg == PH_DATA)
                begin
                    buf_port.wr_en = proc &&
                                     (count_reg < 32'(adbrx_pkg::MAX_PAYLOAD));
                    sum_next   = sum_reg + {24'd0, s1_item_reg.data_byte};
                    count_next = count_inc;
                end
            end
            adbrx_pkg::ACT_END:
            begin
                if (phase_reg == PH_HEADER)
                begin
                    if (hdr_bad)
                    begin
                        phase_next = PH_ERROR;
                    end
                    else if (hdr_reg[3] == 32'd0)
                    begin
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        phase_next = PH_DATA;
                        count_next = 32'd0;
                        sum_next   = 32'd0;
                    end
                end
                else if (phase_reg == PH_DATA)
                begin
                    phase_next = data_bad ? PH_ERROR : PH_IDLE;
                end
            end
            adbrx_pkg::ACT_IDLE:
            begin
                phase_next = PH_IDLE;
            end
            default:
            begin
            end
        endcase

        out_item_next = '0;
        unique case (phase_next)
            PH_IDLE:
            begin
                out_item_next.status          = adbrx_pkg::ST_OK;
                out_item_next.command         = hdr_next[0];
                out_item_next.first_argument  = hdr_next[1];
                out_item_next.second_argument = hdr_next[2];
                out_item_next.payload_len     = hdr_next[3];
            end
            PH_ERROR: out_item_next.status = adbrx_pkg::ST_ERROR;
            default:  out_item_next.status = adbrx_pkg::ST_BUSY;
        endcase
    end

    // state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            for (int i = 0; i < 6; i++)
            begin
                hdr_reg[i] <= 32'd0;
            end
            count_reg      <= 32'd0;
            sum_reg        <= 32'd0;
            out_valid_reg  <= 1'b0;
            out_item_reg   <= '0;
            out_rd_sel_reg <= 1'b0;
        end
        else
        begin
            if (proc)
            begin
                phase_reg      <= phase_next;
                hdr_reg        <= hdr_next;
                count_reg      <= count_next;
                sum_reg        <= sum_next;
                out_item_reg   <= out_item_next;
                out_rd_sel_reg <= (s1_item_reg.action == adbrx_pkg::ACT_READ) && rd_in_range;
            end
            if (advance)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    adbrx_payload_buf u_payload_buf
    (
        .clk     (clk),
        .port    (buf_port),
        .rd_data (rd_data)
    );

    always_comb
    begin
        rsp_data           = out_item_reg;
        rsp_data.read_byte = out_rd_sel_reg ? rd_data : 8'd0;
    end

    assign rsp_ch.valid = out_valid_reg;
    assign rsp_ch.data  = rsp_data;

    // header words only show while idle
    a_hdr_hidden: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_item_reg.status != adbrx_pkg::ST_OK) |->
        (out_item_reg.command == 32'd0 && out_item_reg.payload_len == 32'd0))
        else $error("header fields visible outside ok status");

    // payload phase is only entered with a nonzero length
    a_data_len: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DATA) |-> (hdr_reg[3] != 32'd0))
        else $error("payload phase with zero length");

    // a full input register behind a stalled result takes no new request
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && !rsp_ch.ready) |-> !req_ch.ready)
        else $error("request accepted while pipeline is full");

    // state only moves when a request is processed
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !proc |=> ($stable(phase_reg) && $stable(count_reg) && $stable(sum_reg)))
        else $error("state changed without a request");

    // read byte is zero unless a read request produced it
    a_rd_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_rd_sel_reg) |-> (rsp_ch.data.read_byte == 8'd0))
        else $error("read byte nonzero for non-read request");

endmodule

@@ rtl/core/adbrx_payload_buf.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adbrx_payload_buf
// Payload byte buffer: one write port, one registered read port.
// ----------------------------------------------------------------------------
module adbrx_payload_buf
(
    input  logic                    clk,
    input  adbrx_pkg::payload_req_t port,
    output logic [7:0]              rd_data
);

    logic [7:0] mem [adbrx_pkg::MAX_PAYLOAD];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (port.wr_en)
        begin
            mem[port.wr_addr] <= port.wr_data;
        end
        if (port.rd_en)
        begin
            rd_data_reg <= mem[port.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ tb/adb_packet_receive_checker_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adb_packet_receive_checker_tb
// Drives arm, byte, transfer-end, idle and read requests into the receive
// checker and compares every result against a cycle-free predictor of the
// header/payload checks. Covers good and broken messages, several length
// limit settings, back-pressure on both channels and a long result stall.
// ----------------------------------------------------------------------------
module adb_packet_receive_checker_tb;

    localparam logic [2:0] ACT_LAST    = 3'd7;
    localparam int         STALL_LIMIT = 2000;
    localparam int         HOLD_CYCLES = 200;

    typedef enum logic [1:0] {RX_IDLE, RX_HEADER, RX_DATA, RX_ERROR} rx_phase_t;

    typedef enum int {
        MSG_GOOD, MSG_BAD_MAGIC, MSG_SHORT_HDR, MSG_LONG_HDR, MSG_HDR_FAIL,
        MSG_TOO_LONG, MSG_PAY_SHORT, MSG_PAY_LONG, MSG_BAD_SUM, MSG_PAY_FAIL,
        MSG_REARM, MSG_ABORT
    } msg_kind_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [12:0] cfg_wr_data;

    adbrx_in_if  req_ch ();
    adbrx_out_if rsp_ch ();

    adb_packet_receive_checker i_dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req_ch      (req_ch),
        .rsp_ch      (rsp_ch)
    );

    always #5 clk = ~clk;

    // predicted receiver state
    rx_phase_t   rx_phase;
    logic [31:0] hdr_word [6];
    logic [31:0] rx_count;
    logic [31:0] rx_sum;
    logic [7:0]  pay_mem [adbrx_pkg::MAX_PAYLOAD];
    logic [12:0] model_max_len;

    adbrx_pkg::in_item_t  request_q [$];
    adbrx_pkg::out_item_t rx_result_q [$];

    // stimulus bookkeeping
    int gen_max_len;
    int stored_hi;      // payload entries [0, stored_hi) are known to be written
    int gen_count;
    int err_count;
    int quiet_cycles;
    int send_gap;
    int recv_gap;
    int hold_left;
    bit idle_on;
    bit hold_request;
    bit req_taken;

    function automatic adbrx_pkg::out_item_t rx_predict(input adbrx_pkg::in_item_t req);
        adbrx_pkg::out_item_t res;
        int                   sh;
        res = '0;
        case (req.action)
            adbrx_pkg::ACT_ARM:
            begin
                rx_phase = RX_HEADER;
                rx_count = '0;
                rx_sum   = '0;
            end
            adbrx_pkg::ACT_BYTE:
            begin
                if (rx_phase == RX_HEADER || rx_phase == RX_DATA)
                begin
                    if (rx_phase == RX_HEADER)
                    begin
                        // bytes past the 24-byte header are only counted
                        if (rx_count < adbrx_pkg::HDR_BYTES)
                        begin
                            sh = 8 * int'(rx_count[1:0]);
                            hdr_word[rx_count[4:2]][sh +: 8] = req.data_byte;
                        end
                    end
                    else
                    begin
                        if (rx_count < adbrx_pkg::MAX_PAYLOAD)
                            pay_mem[rx_count[adbrx_pkg::PAY_AW-1:0]] = req.data_byte;
                        rx_sum = rx_sum + 32'(req.data_byte);
                    end
                    if (rx_count != '1)
                        rx_count = rx_count + 32'd1;
                end
            end
            adbrx_pkg::ACT_END:
            begin
                if (rx_phase == RX_HEADER)
                begin
                    if (!req.transfer_ok || rx_count != adbrx_pkg::HDR_BYTES ||
                        hdr_word[0] != ~hdr_word[5] || hdr_word[3] > 32'(model_max_len))
                        rx_phase = RX_ERROR;
                    else if (hdr_word[3] == '0)
                        rx_phase = RX_IDLE;
                    else
                    begin
                        rx_phase = RX_DATA;
                        rx_count = '0;
                        rx_sum   = '0;
                    end
                end
                else if (rx_phase == RX_DATA)
                begin
                    if (!req.transfer_ok || rx_count != hdr_word[3] || rx_sum != hdr_word[4])
                        rx_phase = RX_ERROR;
                    else
                        rx_phase = RX_IDLE;
                end
            end
            adbrx_pkg::ACT_IDLE:
                rx_phase = RX_IDLE;
            adbrx_pkg::ACT_READ:
            begin
                if (int'(req.read_index) < adbrx_pkg::MAX_PAYLOAD)
                    res.read_byte = pay_mem[req.read_index];
            end
            default:
                ;
        endcase
        case (rx_phase)
            RX_IDLE:
            begin
                res.status          = adbrx_pkg::ST_OK;
                res.command         = hdr_word[0];
                res.first_argument  = hdr_word[1];
                res.second_argument = hdr_word[2];
                res.payload_len     = hdr_word[3];
            end
            RX_ERROR:
                res.status = adbrx_pkg::ST_ERROR;
            default:
                res.status = adbrx_pkg::ST_BUSY;
        endcase
        return res;
    endfunction

    task automatic put_req(input logic [2:0] act, input logic [7:0] dat, input logic ok,
                           input logic [11:0] idx, input bit counted);
        adbrx_pkg::in_item_t it;
        it.action      = act;
        it.data_byte   = dat;
        it.transfer_ok = ok;
        it.read_index  = idx;
        request_q.push_back(it);
        if (counted)
            gen_count++;
    endtask

    task automatic put_byte(input logic [7:0] dat);
        put_req(adbrx_pkg::ACT_BYTE, dat, 1'($urandom), 12'($urandom), 1'b1);
    endtask

    task automatic put_reads();
        int n;
        n = $urandom_range(1, 3);
        if (stored_hi > 0)
            repeat (n)
                put_req(adbrx_pkg::ACT_READ, 8'($urandom), 1'($urandom),
                        12'($urandom_range(0, stored_hi - 1)), 1'b1);
    endtask

    task automatic send_message(input msg_kind_t kind, input int len, input logic [31:0] cmd);
        logic [31:0] w [6];
        logic [7:0]  pay [$];
        logic [31:0] sum;
        int          n_hdr;
        int          n_pay;
        int          cut;
        bit          hdr_good;
        sum = '0;
        for (int i = 0; i < len; i++)
        begin
            pay.push_back(8'($urandom));
            sum = sum + 32'(pay[i]);
        end
        w[0] = cmd;
        w[1] = $urandom;
        w[2] = $urandom;
        w[3] = 32'(len);
        w[4] = sum;
        w[5] = ~cmd;
        case (kind)
            MSG_BAD_MAGIC: w[5] = w[5] ^ (32'd1 << $urandom_range(0, 31));
            MSG_TOO_LONG:  w[3] = ($urandom_range(0, 1) == 0) ? 32'hFFFF_FFFF :
                                  32'(gen_max_len + 1 + $urandom_range(0, 100));
            MSG_BAD_SUM:   w[4] = sum + 32'($urandom_range(1, 255));
            default:       ;
        endcase
        put_req(adbrx_pkg::ACT_ARM, 8'($urandom), 1'($urandom), 12'($urandom), 1'b1);
        if (kind == MSG_REARM)
        begin
            // partial header, then arm again: count restarts, words are overwritten
            repeat ($urandom_range(1, 30))
                put_byte(8'($urandom));
            put_req(adbrx_pkg::ACT_ARM, 8'($urandom), 1'($urandom), 12'($urandom), 1'b1);
        end
        if (kind == MSG_ABORT && (len == 0 || $urandom_range(0, 1) == 0))
        begin
            cut = $urandom_range(0, 23);
            for (int k = 0; k < cut; k++)
                put_byte(w[k >> 2][8 * (k % 4) +: 8]);
            put_req(adbrx_pkg::ACT_IDLE, 8'($urandom), 1'($urandom), 12'($urandom), 1'b1);
            return;
        end
        n_hdr = 24;
        if (kind == MSG_SHORT_HDR)
            n_hdr = $urandom_range(0, 23);
        else if (kind == MSG_LONG_HDR)
            n_hdr = $urandom_range(25, 28);
        for (int k = 0; k < n_hdr; k++)
            put_byte((k < 24) ? w[k >> 2][8 * (k % 4) +: 8] : 8'($urandom));
        put_req(adbrx_pkg::ACT_END, 8'($urandom), (kind != MSG_HDR_FAIL), 12'($urandom), 1'b1);
        hdr_good = !(kind inside {MSG_BAD_MAGIC, MSG_SHORT_HDR, MSG_LONG_HDR,
                                  MSG_HDR_FAIL, MSG_TOO_LONG});
        if (!hdr_good)
        begin
            // stray bytes while in error are dropped by the block
            repeat ($urandom_range(0, 2))
                put_req(adbrx_pkg::ACT_BYTE, 8'($urandom), 1'($urandom), 12'($urandom),
                        1'b0);
            return;
        end
        if (len == 0)
            return;
        n_pay = len;
        if (kind == MSG_PAY_SHORT || kind == MSG_ABORT)
            n_pay = $urandom_range(0, len - 1);
        else if (kind == MSG_PAY_LONG)
            n_pay = len + $urandom_range(1, 3);
        for (int k = 0; k < n_pay; k++)
            put_byte((k < len) ? pay[k] : 8'($urandom));
        if (((n_pay < adbrx_pkg::MAX_PAYLOAD) ? n_pay : adbrx_pkg::MAX_PAYLOAD) > stored_hi)
            stored_hi = (n_pay < adbrx_pkg::MAX_PAYLOAD) ? n_pay : adbrx_pkg::MAX_PAYLOAD;
        if (kind == MSG_ABORT)
        begin
            put_req(adbrx_pkg::ACT_IDLE, 8'($urandom), 1'($urandom), 12'($urandom), 1'b1);
            return;
        end
        put_req(adbrx_pkg::ACT_END, 8'($urandom), (kind != MSG_PAY_FAIL), 12'($urandom), 1'b1);
    endtask

    task automatic run_random(input int n_items);
        int         start;
        int         r;
        int         len;
        int         hi;
        logic [2:0] act;
        msg_kind_t  kind;
        start = gen_count;
        while (gen_count - start < n_items)
        begin
            r = $urandom_range(0, 99);
            if (r < 75)
            begin
                kind = (r < 30) ? MSG_GOOD :
                       msg_kind_t'($urandom_range(MSG_BAD_MAGIC, MSG_ABORT));
                hi   = ($urandom_range(0, 9) == 0) ? 64 : 12;
                if (gen_max_len < hi)
                    hi = gen_max_len;
                len  = $urandom_range(0, hi);
                send_message(kind, len, $urandom);
            end
            else if (r < 90)
                put_reads();
            else
            begin
                // loose requests with no message structure
                repeat ($urandom_range(1, 4))
                begin
                    do
                        act = 3'($urandom);
                    while (act == adbrx_pkg::ACT_READ);
                    put_req(act, 8'($urandom), 1'($urandom), 12'($urandom), 1'b0);
                end
            end
        end
    endtask

    task automatic wait_drained();
        while (!(request_q.size() == 0 && !req_ch.valid && rx_result_q.size() == 0))
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_max_len(input logic [12:0] v);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        model_max_len = v;
        gen_max_len   = int'(v);
    endtask

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            err_count++;
        end
    endtask

    // request side: accept at the rising edge, drive at the falling edge
    always @(posedge clk)
    begin
        if (rst_n && req_ch.valid && req_ch.ready)
        begin
            rx_result_q.push_back(rx_predict(req_ch.data));
            req_taken = 1'b1;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n && (!req_ch.valid || req_taken))
        begin
            req_taken = 1'b0;
            if (send_gap == 0 && idle_on && $urandom_range(0, 9) == 0)
                send_gap = $urandom_range(1, 4);
            if (send_gap > 0)
            begin
                send_gap--;
                req_ch.valid <= 1'b0;
            end
            else if (request_q.size() > 0)
            begin
                req_ch.valid <= 1'b1;
                req_ch.data  <= request_q.pop_front();
            end
            else
                req_ch.valid <= 1'b0;
        end
    end

    // result side
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                if (recv_gap == 0 && idle_on && $urandom_range(0, 9) == 0)
                    recv_gap = $urandom_range(1, 4);
                if (recv_gap > 0)
                begin
                    recv_gap--;
                    rsp_ch.ready <= 1'b0;
                end
                else
                    rsp_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        adbrx_pkg::out_item_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (rx_result_q.size() == 0)
            begin
                $display("%0t: result with no request pending, got status %0h",
                         $time, rsp_ch.data.status);
                err_count++;
            end
            else
            begin
                want = rx_result_q.pop_front();
                check_field("status", 32'(want.status), 32'(rsp_ch.data.status));
                check_field("command", want.command, rsp_ch.data.command);
                check_field("first_argument", want.first_argument,
                            rsp_ch.data.first_argument);
                check_field("second_argument", want.second_argument,
                            rsp_ch.data.second_argument);
                check_field("payload_len", want.payload_len, rsp_ch.data.payload_len);
                check_field("read_byte", 32'(want.read_byte), 32'(rsp_ch.data.read_byte));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, quiet_cycles);
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = '0;
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        rsp_ch.ready = 1'b0;
        idle_on      = 1'b1;
        hold_request = 1'b0;
        req_taken    = 1'b0;
        send_gap     = 0;
        recv_gap     = 0;
        hold_left    = 0;
        quiet_cycles = 0;
        err_count    = 0;
        gen_count    = 0;
        stored_hi    = 0;
        rx_phase      = RX_IDLE;
        rx_count      = '0;
        rx_sum        = '0;
        model_max_len = adbrx_pkg::MAX_LEN_RST;
        gen_max_len   = int'(adbrx_pkg::MAX_LEN_RST);
        for (int i = 0; i < 6; i++)
            hdr_word[i] = '0;
        for (int i = 0; i < adbrx_pkg::MAX_PAYLOAD; i++)
            pay_mem[i] = '0;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // requests that do nothing while idle, unused action codes, return to idle
        put_byte(8'h00);
        put_byte(8'hFF);
        put_req(adbrx_pkg::ACT_END, 8'h00, 1'b1, 12'h000, 1'b1);
        put_req(adbrx_pkg::ACT_END, 8'hFF, 1'b0, 12'hFFF, 1'b1);
        for (int a = int'(adbrx_pkg::ACT_READ) + 1; a <= int'(ACT_LAST); a++)
            put_req(3'(a), 8'($urandom), 1'($urandom), 12'($urandom), 1'b1);
        put_req(adbrx_pkg::ACT_IDLE, 8'($urandom), 1'($urandom), 12'($urandom), 1'b1);
        // zero-length message goes straight to idle
        send_message(MSG_GOOD, 0, 32'hFFFF_FFFF);
        send_message(MSG_GOOD, 3, 32'h0000_0000);
        put_req(adbrx_pkg::ACT_READ, 8'h00, 1'b0, 12'd0, 1'b1);
        put_req(adbrx_pkg::ACT_READ, 8'hFF, 1'b1, 12'd2, 1'b1);
        put_reads();
        run_random(200);
        wait_drained();

        write_max_len(13'd0);
        run_random(100);
        wait_drained();

        write_max_len(13'd1);
        run_random(100);
        hold_request = 1'b1;
        wait_drained();

        write_max_len(13'd4095);
        run_random(120);
        wait_drained();

        write_max_len(13'd7);
        run_random(100);
        wait_drained();

        write_max_len(13'($urandom_range(0, 4096)));
        run_random(100);
        wait_drained();

        // closing stretch at full throughput
        idle_on = 1'b0;
        write_max_len(adbrx_pkg::MAX_LEN_RST);
        run_random(120);
        wait_drained();
        repeat (10) @(posedge clk);

        if (rx_result_q.size() != 0)
            $display("%0t: %0d expected results never arrived", $time, rx_result_q.size());
        if (err_count == 0 && rx_result_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
